FILE: hw/rtl/hsv_rgb_led_pwm_driver_macros.svh
// Assertion macros shared by the checker.
`ifndef HSV_RGB_LED_PWM_DRIVER_MACROS_SVH
`define HSV_RGB_LED_PWM_DRIVER_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define HRLPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define HRLPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also watches through reset.
`define HRLPD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/hrlpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrlpd_pkg;

  // Default reload value of the PWM down-counter
  localparam int unsigned PWM_TOP_DEF = 255;

  // Item kinds
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Reciprocal of 60 in 20 fractional bits, rounded up; exact for v*w <= 15300
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_MUL   = 17477;

  typedef struct packed {
    logic       cmd;
    logic [8:0] hue;
    logic [7:0] value;
  } hrlpd_in_t;

  typedef struct packed {
    logic       red_pin;
    logic       green_pin;
    logic       blue_pin;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } hrlpd_out_t;

  // Scale the sector weight (0..60) by 2^20/60, so v*scale >> 20 = v*w/60
  function automatic logic [20:0] x_scale(input logic [5:0] w);
    x_scale = 21'(32'(w) * RECIP_MUL);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hsv_rgb_led_pwm_driver.sv
`timescale 1ns / 1ps
`default_nettype none
// HSV to RGB LED PWM driver.
// Input channel (in_valid/in_ready/in_data) carries one beat per command:
//   cmd = set colour: hue (degrees) and value become red/green/blue duties
//   at full saturation; the pins and the PWM counter are left alone.
//   cmd = tick: one step of the down-counting PWM; a pin goes low (lit)
//   when the counter meets that channel's duty, all pins go high on reload.
// Output channel (out_valid/out_ready/out_data) returns one beat per input
// beat: the three pin levels and the three stored duties after that beat.
// Path: an input beat is held in the input register, then conversion and state
// update write the output register, which raises out_valid.
// Throughput: one beat per cycle unless the output stalls; the conversion is a
// single 8x21 multiply by a scaled weight, and the state update settles within that cycle.
// Stall: while out_ready is low and a result is waiting, one more beat is
// held in the input register, then in_ready drops until the result leaves.
// Reset (rst_n low, synchronous): counter and duties clear, pins go high
// (LEDs off), both stages empty.
module hsv_rgb_led_pwm_driver
  import hrlpd_pkg::*;
#(
  parameter int unsigned PWM_TOP = PWM_TOP_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire hrlpd_in_t  in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output hrlpd_out_t      out_data
);

  localparam int unsigned CNT_W = $clog2(PWM_TOP + 1);
  localparam int unsigned CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(PWM_TOP);

  // Pipeline registers
  logic       s1_vld_r;
  hrlpd_in_t  s1_data_r;
  logic       out_vld_r;
  hrlpd_out_t out_data_r;

  // Block state
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       red_duty_r, red_duty_nxt;
  logic [7:0]       green_duty_r, green_duty_nxt;
  logic [7:0]       blue_duty_r, blue_duty_nxt;
  logic [2:0]       pins_r, pins_nxt;

  logic advance;
  logic fire;

  // Conversion path
  logic [8:0]  hue_mod;
  logic [6:0]  hue_m;
  logic [5:0]  hue_dist;
  logic [5:0]  weight;
  logic [28:0] prod;
  logic [7:0]  x_term;
  logic [7:0]  conv_red, conv_green, conv_blue;

  // Tick path
  logic             cnt_zero;
  logic [CNT_W-1:0] cnt_eff;
  logic [CMP_W-1:0] cnt_cmp;
  logic [2:0]       pins_tick;

  // Advance the output stage when it is empty or being drained
  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !s1_vld_r || advance;
  assign fire     = s1_vld_r && advance;

  // Capture input beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Reduce hue modulo 120 by range
  always_comb begin
    if (s1_data_r.hue >= 9'd480) begin
      hue_mod = s1_data_r.hue - 9'd480;
    end else if (s1_data_r.hue >= 9'd360) begin
      hue_mod = s1_data_r.hue - 9'd360;
    end else if (s1_data_r.hue >= 9'd240) begin
      hue_mod = s1_data_r.hue - 9'd240;
    end else if (s1_data_r.hue >= 9'd120) begin
      hue_mod = s1_data_r.hue - 9'd120;
    end else begin
      hue_mod = s1_data_r.hue;
    end
  end

  // Weight = 60 - |m - 60|, then X = value * weight / 60
  assign hue_m    = hue_mod[6:0];
  assign hue_dist = (hue_m >= 7'd60) ? 6'(hue_m - 7'd60) : 6'(7'd60 - hue_m);
  assign weight   = 6'd60 - hue_dist;
  assign prod     = 29'(s1_data_r.value) * 29'(x_scale(weight));
  assign x_term   = 8'(prod >> RECIP_SHIFT);

  // Pick duties by 60-degree sector; hue 300 and up lands in the last one
  always_comb begin
    if (s1_data_r.hue < 9'd60) begin
      conv_red = s1_data_r.value; conv_green = x_term;         conv_blue = 8'd0;
    end else if (s1_data_r.hue < 9'd120) begin
      conv_red = x_term;          conv_green = s1_data_r.value; conv_blue = 8'd0;
    end else if (s1_data_r.hue < 9'd180) begin
      conv_red = 8'd0;            conv_green = s1_data_r.value; conv_blue = x_term;
    end else if (s1_data_r.hue < 9'd240) begin
      conv_red = 8'd0;            conv_green = x_term;  conv_blue = s1_data_r.value;
    end else if (s1_data_r.hue < 9'd300) begin
      conv_red = x_term;          conv_green = 8'd0;    conv_blue = s1_data_r.value;
    end else begin
      conv_red = s1_data_r.value; conv_green = 8'd0;    conv_blue = x_term;
    end
  end

  // PWM step: reload at zero, drop each pin whose duty matches the count
  assign cnt_zero = (cnt_r == '0);
  assign cnt_eff  = cnt_zero ? CNT_TOP : cnt_r;
  assign cnt_cmp  = CMP_W'(cnt_eff);

  always_comb begin
    pins_tick = cnt_zero ? 3'b111 : pins_r;
    if (CMP_W'(red_duty_r) == cnt_cmp) begin
      pins_tick[0] = 1'b0;
    end
    if (CMP_W'(green_duty_r) == cnt_cmp) begin
      pins_tick[1] = 1'b0;
    end
    if (CMP_W'(blue_duty_r) == cnt_cmp) begin
      pins_tick[2] = 1'b0;
    end
  end

  // Next state for the beat in the input register
  always_comb begin
    cnt_nxt        = cnt_r;
    red_duty_nxt   = red_duty_r;
    green_duty_nxt = green_duty_r;
    blue_duty_nxt  = blue_duty_r;
    pins_nxt       = pins_r;
    if (fire) begin
      case (s1_data_r.cmd)
        CMD_SET: begin
          red_duty_nxt   = conv_red;
          green_duty_nxt = conv_green;
          blue_duty_nxt  = conv_blue;
        end
        CMD_TICK: begin
          pins_nxt = pins_tick;
          cnt_nxt  = cnt_eff - CNT_W'(1);
        end
        default: begin
          pins_nxt = pins_r;
        end
      endcase
    end
  end

  // Update state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      red_duty_r   <= 8'd0;
      green_duty_r <= 8'd0;
      blue_duty_r  <= 8'd0;
      pins_r       <= 3'b111;
    end else begin
      cnt_r        <= cnt_nxt;
      red_duty_r   <= red_duty_nxt;
      green_duty_r <= green_duty_nxt;
      blue_duty_r  <= blue_duty_nxt;
      pins_r       <= pins_nxt;
    end
  end

  // Output stage: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.red_pin     <= pins_nxt[0];
      out_data_r.green_pin   <= pins_nxt[1];
      out_data_r.blue_pin    <= pins_nxt[2];
      out_data_r.red_level   <= red_duty_nxt;
      out_data_r.green_level <= green_duty_nxt;
      out_data_r.blue_level  <= blue_duty_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/hrlpd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_rgb_led_pwm_driver_macros.svh"

module hrlpd_checker
  import hrlpd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire hrlpd_out_t out_data
);

  // A waiting result beat stays put until it is taken
  `HRLPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "out beat changed while stalled")

  // Input back-pressure only comes from a stalled result
  `HRLPD_ASSERT_NOW(a_ready_cause, clk, rst_n, !in_ready, out_valid && !out_ready, "in_ready low without an output stall")

  // Reset empties the output stage
  `HRLPD_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "out_valid high after reset")

  // A stalled input beat must still be offered next cycle
  `HRLPD_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid, "in_valid dropped while stalled")

endmodule

bind hsv_rgb_led_pwm_driver hrlpd_checker u_hrlpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
